// ===== rtl/lfpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpr_pkg
// Types and constants shared by the level frame parser and responder.
// ----------------------------------------------------------------------------
package lfpr_pkg;

	// event codes of a result beat
	localparam logic [2:0] EV_RESPONSE      = 3'd0;
	localparam logic [2:0] EV_LEVEL_UPDATED = 3'd1;
	localparam logic [2:0] EV_LEVEL_CSUM    = 3'd2;
	localparam logic [2:0] EV_REQ_CSUM      = 3'd3;
	localparam logic [2:0] EV_DROPPED       = 3'd4;

	// configuration register indexes
	localparam logic [7:0] REG_START_DELIM = 8'd0;
	localparam logic [7:0] REG_END_DELIM   = 8'd1;
	localparam logic [7:0] REG_LEVEL_TYPE  = 8'd2;
	localparam logic [7:0] REG_REQ_TYPE    = 8'd3;

	// reset values
	localparam logic [7:0]  START_DELIM_RST = 8'hA5;
	localparam logic [7:0]  END_DELIM_RST   = 8'h5A;
	localparam logic [7:0]  LEVEL_TYPE_RST  = 8'd201;
	localparam logic [7:0]  REQ_TYPE_RST    = 8'd106;
	localparam logic [15:0] LEVEL_RST       = 16'd65000;

	// response frame
	localparam logic [7:0] RESP_LEN_BYTE = 8'd2;
	localparam logic [2:0] RESP_LAST_IDX = 3'd6;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  tx_byte;
		logic        last;
		logic [15:0] level;
		logic [31:0] update_count;
	} out_item_t;

	typedef struct packed {
		logic [7:0] start_delim;
		logic [7:0] end_delim;
		logic [7:0] level_type;
		logic [7:0] req_type;
	} cfg_t;

	// one unit of work for the back end
	typedef struct packed {
		logic        respond;
		logic [2:0]  event_code;
		logic [15:0] level;
		logic [31:0] count;
	} job_t;

	typedef enum logic [2:0] {
		REQ_IDLE,
		REQ_TYPE,
		REQ_LEN,
		REQ_CSUM,
		REQ_END
	} req_state_t;

endpackage

// ===== rtl/lfpr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpr_front
// Byte parsers for both links; classifies completed frames into jobs and
// keeps the stored level and update count.
// ----------------------------------------------------------------------------
module lfpr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  lfpr_pkg::in_item_t in_item,
	input  lfpr_pkg::cfg_t    cfg,
	output logic              push,
	output lfpr_pkg::job_t    job
);

	localparam logic [8:0] MPOS_IDLE = 9'd0;
	localparam logic [8:0] MPOS_TYPE = 9'd1;
	localparam logic [8:0] MPOS_LEN  = 9'd2;
	localparam logic [8:0] MPOS_CSUM = 9'd3;
	localparam logic [8:0] MPOS_BODY = 9'd4;
	localparam logic [8:0] MPOS_HIGH = 9'd4;
	localparam logic [8:0] MPOS_LOW  = 9'd5;

	logic [8:0]  meas_pos_q, meas_pos_n;
	logic [7:0]  meas_len_q, meas_len_n;
	logic [7:0]  meas_sum_q, meas_sum_n;
	logic [7:0]  meas_csum_q, meas_csum_n;
	logic [7:0]  meas_hi_q, meas_hi_n;
	logic [7:0]  meas_lo_q, meas_lo_n;
	lfpr_pkg::req_state_t req_state_q, req_state_n;
	logic [7:0]  req_sum_q, req_sum_n;
	logic [7:0]  req_csum_q, req_csum_n;
	logic [15:0] level_q, level_n;
	logic [31:0] count_q, count_n;

	logic [7:0] b;
	logic [7:0] meas_sum_add;
	logic [7:0] req_sum_add;
	logic [7:0] meas_neg;
	logic [7:0] req_neg;
	logic [8:0] meas_end_pos;
	logic       resp_n;
	logic [2:0] event_n;

	assign b            = in_item.rx_byte;
	assign meas_sum_add = meas_sum_q + b;
	assign req_sum_add  = req_sum_q + b;
	assign meas_neg     = 8'd0 - meas_sum_add;
	assign req_neg      = 8'd0 - req_sum_add;
	assign meas_end_pos = MPOS_BODY + {1'b0, meas_len_q};

	always_comb begin
		meas_pos_n  = meas_pos_q;
		meas_len_n  = meas_len_q;
		meas_sum_n  = meas_sum_q;
		meas_csum_n = meas_csum_q;
		meas_hi_n   = meas_hi_q;
		meas_lo_n   = meas_lo_q;
		req_state_n = req_state_q;
		req_sum_n   = req_sum_q;
		req_csum_n  = req_csum_q;
		level_n     = level_q;
		count_n     = count_q;
		push        = 1'b0;
		resp_n      = 1'b0;
		event_n     = lfpr_pkg::EV_DROPPED;
		if (accept && !in_item.command) begin
			case (meas_pos_q)
				MPOS_IDLE: begin
					if (b == cfg.start_delim) begin
						meas_sum_n = b;
						meas_pos_n = MPOS_TYPE;
					end
				end
				MPOS_TYPE: begin
					if (b == cfg.level_type) begin
						meas_sum_n = meas_sum_add;
						meas_pos_n = MPOS_LEN;
					end else begin
						meas_pos_n = MPOS_IDLE;
					end
				end
				MPOS_LEN: begin
					meas_len_n = b;
					meas_sum_n = meas_sum_add;
					meas_pos_n = MPOS_CSUM;
				end
				MPOS_CSUM: begin
					meas_csum_n = b;
					meas_pos_n  = MPOS_BODY;
				end
				default: begin
					meas_sum_n = meas_sum_add;
					if (meas_pos_q < meas_end_pos) begin
						if (meas_pos_q == MPOS_HIGH) begin
							meas_hi_n = b;
						end
						if (meas_pos_q == MPOS_LOW) begin
							meas_lo_n = b;
						end
						meas_pos_n = meas_pos_q + 9'd1;
					end else begin
						// end position: frame is judged here
						meas_pos_n = MPOS_IDLE;
						push       = 1'b1;
						if (b != cfg.end_delim) begin
							event_n = lfpr_pkg::EV_DROPPED;
						end else if (meas_neg != meas_csum_q) begin
							event_n = lfpr_pkg::EV_LEVEL_CSUM;
						end else if (meas_len_q < 8'd2) begin
							event_n = lfpr_pkg::EV_DROPPED;
						end else begin
							event_n = lfpr_pkg::EV_LEVEL_UPDATED;
							level_n = {meas_hi_q, meas_lo_q};
							count_n = count_q + 32'd1;
						end
					end
				end
			endcase
		end
		if (accept && in_item.command) begin
			case (req_state_q)
				lfpr_pkg::REQ_IDLE: begin
					if (b == cfg.start_delim) begin
						req_sum_n   = b;
						req_state_n = lfpr_pkg::REQ_TYPE;
					end
				end
				lfpr_pkg::REQ_TYPE: begin
					if (b == cfg.req_type) begin
						req_sum_n   = req_sum_add;
						req_state_n = lfpr_pkg::REQ_LEN;
					end else begin
						req_state_n = lfpr_pkg::REQ_IDLE;
					end
				end
				lfpr_pkg::REQ_LEN: begin
					req_state_n = (b == 8'd0) ? lfpr_pkg::REQ_CSUM : lfpr_pkg::REQ_IDLE;
				end
				lfpr_pkg::REQ_CSUM: begin
					req_csum_n  = b;
					req_state_n = lfpr_pkg::REQ_END;
				end
				lfpr_pkg::REQ_END: begin
					// waits here until the end delimiter shows up
					if (b == cfg.end_delim) begin
						req_state_n = lfpr_pkg::REQ_IDLE;
						push        = 1'b1;
						if (req_neg != req_csum_q) begin
							event_n = lfpr_pkg::EV_REQ_CSUM;
						end else begin
							resp_n  = 1'b1;
							event_n = lfpr_pkg::EV_RESPONSE;
						end
					end
				end
				default: begin
					req_state_n = lfpr_pkg::REQ_IDLE;
				end
			endcase
		end
		job.respond    = resp_n;
		job.event_code = event_n;
		job.level      = level_n;
		job.count      = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_pos_q  <= MPOS_IDLE;
			req_state_q <= lfpr_pkg::REQ_IDLE;
			level_q     <= lfpr_pkg::LEVEL_RST;
			count_q     <= '0;
		end else begin
			meas_pos_q  <= meas_pos_n;
			req_state_q <= req_state_n;
			level_q     <= level_n;
			count_q     <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		meas_len_q  <= meas_len_n;
		meas_sum_q  <= meas_sum_n;
		meas_csum_q <= meas_csum_n;
		meas_hi_q   <= meas_hi_n;
		meas_lo_q   <= meas_lo_n;
		req_sum_q   <= req_sum_n;
		req_csum_q  <= req_csum_n;
	end

endmodule

// ===== rtl/lfpr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpr_queue
// Short job queue between the parsers and the result sequencer.
// ----------------------------------------------------------------------------
module lfpr_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lfpr_pkg::job_t push_job,
	input  logic           pop,
	output lfpr_pkg::job_t head_job,
	output logic           full,
	output logic           not_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	lfpr_pkg::job_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_job  = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/lfpr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpr_back
// Expands queued jobs into result beats: one event beat, or the seven
// bytes of a level response, into a registered output stage.
// ----------------------------------------------------------------------------
module lfpr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  lfpr_pkg::job_t     job,
	input  lfpr_pkg::cfg_t     cfg,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output lfpr_pkg::out_item_t out_data
);

	logic [2:0]          idx_q;
	logic                out_valid_q;
	lfpr_pkg::out_item_t out_data_q;
	lfpr_pkg::out_item_t beat;
	logic                load;
	logic [7:0]          resp_sum;
	logic [7:0]          resp_csum;
	logic [7:0]          resp_byte;
	logic                resp_last;

	assign load      = job_valid && (!out_valid_q || !out_stall);
	assign resp_last = (idx_q == lfpr_pkg::RESP_LAST_IDX);
	assign pop       = load && (!job.respond || resp_last);
	assign resp_sum  = cfg.start_delim + cfg.level_type + lfpr_pkg::RESP_LEN_BYTE
		+ job.level[15:8] + job.level[7:0] + cfg.end_delim;
	assign resp_csum = 8'd0 - resp_sum;

	always_comb begin
		case (idx_q)
			3'd0:    resp_byte = cfg.start_delim;
			3'd1:    resp_byte = cfg.level_type;
			3'd2:    resp_byte = lfpr_pkg::RESP_LEN_BYTE;
			3'd3:    resp_byte = resp_csum;
			3'd4:    resp_byte = job.level[15:8];
			3'd5:    resp_byte = job.level[7:0];
			default: resp_byte = cfg.end_delim;
		endcase
		beat.level        = job.level;
		beat.update_count = job.count;
		if (job.respond) begin
			beat.event_res = lfpr_pkg::EV_RESPONSE;
			beat.tx_byte   = resp_byte;
			beat.last      = resp_last;
		end else begin
			beat.event_res = job.event_code;
			beat.tx_byte   = 8'd0;
			beat.last      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (job.respond) begin
					idx_q <= resp_last ? 3'd0 : idx_q + 3'd1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/level_frame_parser_responder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_frame_parser_responder
// Parses level frames and level requests from two byte links and answers
// requests with a seven-byte level response frame.
// ----------------------------------------------------------------------------
//  channel  | flow control       | payload
//  ---------+--------------------+-----------------------------------------
//  in       | in_valid/in_stall  | in_data: command, rx_byte
//  out      | out_valid/out_stall| out_data: event, byte, last, level, count
//  cfg      | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
//  One byte accepted per cycle while in_stall is low; the parsers judge each
//  byte in that cycle. A result beat is registered in the job queue and then
//  in the output register of the result sequencer; beats leave one per cycle
//  while out_stall is low; a response is seven beats. The job queue lets
//  bytes keep coming while responses drain; in_stall rises only when full.
//  Reset brings the registers to their defaults, both parsers to idle and the
//  level to 65000; no clearing pass is needed.
// ----------------------------------------------------------------------------
module level_frame_parser_responder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lfpr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lfpr_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	lfpr_pkg::cfg_t cfg_q;
	lfpr_pkg::job_t front_job;
	lfpr_pkg::job_t head_job;
	logic           front_push;
	logic           queue_full;
	logic           queue_nonempty;
	logic           back_pop;
	logic           accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = queue_full;
	assign accept    = in_valid && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_delim <= lfpr_pkg::START_DELIM_RST;
			cfg_q.end_delim   <= lfpr_pkg::END_DELIM_RST;
			cfg_q.level_type  <= lfpr_pkg::LEVEL_TYPE_RST;
			cfg_q.req_type    <= lfpr_pkg::REQ_TYPE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lfpr_pkg::REG_START_DELIM: cfg_q.start_delim <= cfg_data;
				lfpr_pkg::REG_END_DELIM:   cfg_q.end_delim   <= cfg_data;
				lfpr_pkg::REG_LEVEL_TYPE:  cfg_q.level_type  <= cfg_data;
				lfpr_pkg::REG_REQ_TYPE:    cfg_q.req_type    <= cfg_data;
				default: ;
			endcase
		end
	end

	lfpr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_item (in_data),
		.cfg     (cfg_q),
		.push    (front_push),
		.job     (front_job)
	);

	lfpr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_push),
		.push_job  (front_job),
		.pop       (back_pop),
		.head_job  (head_job),
		.full      (queue_full),
		.not_empty (queue_nonempty)
	);

	lfpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (queue_nonempty),
		.job       (head_job),
		.cfg       (cfg_q),
		.pop       (back_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/lfpr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpr_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lfpr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input lfpr_pkg::out_item_t out_data
);

	// a stalled beat stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result beat changed while stalled");

	// event beats carry no byte and close their item
	a_event_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_res != lfpr_pkg::EV_RESPONSE) |->
		out_data.last && (out_data.tx_byte == 8'd0))
		else $error("event beat without last or with a byte");

	// response bytes follow each other without gaps
	a_resp_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (out_data.event_res == lfpr_pkg::EV_RESPONSE)
		&& !out_data.last |=> out_valid
		&& (out_data.event_res == lfpr_pkg::EV_RESPONSE))
		else $error("gap inside response frame");

endmodule

bind level_frame_parser_responder lfpr_checker u_lfpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== tb/sv/level_frame_parser_responder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_frame_parser_responder_test
// Feeds level frames and level requests on both links, interleaved, under
// several delimiter and type settings. Each accepted byte is run through a
// behavioral copy of both parsers, and every result beat is checked in order.
// ----------------------------------------------------------------------------
import lfpr_pkg::*;

class frame_tracker;
	logic [7:0]  start_delim = START_DELIM_RST;
	logic [7:0]  end_delim = END_DELIM_RST;
	logic [7:0]  level_type_code = LEVEL_TYPE_RST;
	logic [7:0]  req_type_code = REQ_TYPE_RST;

	logic [8:0]  meas_pos = '0;
	logic [7:0]  meas_len = '0;
	logic [7:0]  meas_sum = '0;
	logic [7:0]  meas_csum = '0;
	logic [7:0]  meas_hi = '0;
	logic [7:0]  meas_lo = '0;
	req_state_t  req_pos = REQ_IDLE;
	logic [7:0]  req_sum = '0;
	logic [7:0]  req_csum = '0;
	logic [15:0] level = LEVEL_RST;
	logic [31:0] count = '0;

	out_item_t   awaited[$];
	int          predicted = 0;
	int          errors = 0;

	function void set_reg(logic [7:0] idx, logic [7:0] val);
		case (idx)
			REG_START_DELIM: start_delim = val;
			REG_END_DELIM:   end_delim = val;
			REG_LEVEL_TYPE:  level_type_code = val;
			REG_REQ_TYPE:    req_type_code = val;
			default: ;
		endcase
	endfunction

	function void push_beat(logic [2:0] ev, logic [7:0] tx, logic fin);
		out_item_t o;
		o.event_res = ev;
		o.tx_byte = tx;
		o.last = fin;
		o.level = level;
		o.update_count = count;
		awaited.push_back(o);
		predicted++;
	endfunction

	function void parse_meas(logic [7:0] b);
		logic [7:0] neg;
		case (meas_pos)
			9'd0: begin
				if (b == start_delim) begin
					meas_sum = b;
					meas_pos = 9'd1;
				end
			end
			9'd1: begin
				if (b == level_type_code) begin
					meas_sum += b;
					meas_pos = 9'd2;
				end else begin
					meas_pos = 9'd0;
				end
			end
			9'd2: begin
				meas_len = b;
				meas_sum += b;
				meas_pos = 9'd3;
			end
			9'd3: begin
				meas_csum = b;
				meas_pos = 9'd4;
			end
			default: begin
				meas_sum += b;
				if (meas_pos < 9'd4 + {1'b0, meas_len}) begin
					if (meas_pos == 9'd4)
						meas_hi = b;
					else if (meas_pos == 9'd5)
						meas_lo = b;
					meas_pos = meas_pos + 9'd1;
				end else begin
					meas_pos = 9'd0;
					neg = -meas_sum;
					if (b != end_delim) begin
						push_beat(EV_DROPPED, 8'h00, 1'b1);
					end else if (neg != meas_csum) begin
						push_beat(EV_LEVEL_CSUM, 8'h00, 1'b1);
					end else if (meas_len < 8'd2) begin
						push_beat(EV_DROPPED, 8'h00, 1'b1);
					end else begin
						level = {meas_hi, meas_lo};
						count = count + 32'd1;
						push_beat(EV_LEVEL_UPDATED, 8'h00, 1'b1);
					end
				end
			end
		endcase
	endfunction

	function void parse_req(logic [7:0] b);
		logic [7:0] rsp [7];
		logic [7:0] s;
		case (req_pos)
			REQ_IDLE: begin
				if (b == start_delim) begin
					req_sum = b;
					req_pos = REQ_TYPE;
				end
			end
			REQ_TYPE: begin
				if (b == req_type_code) begin
					req_sum += b;
					req_pos = REQ_LEN;
				end else begin
					req_pos = REQ_IDLE;
				end
			end
			REQ_LEN: req_pos = (b == 8'h00) ? REQ_CSUM : REQ_IDLE;
			REQ_CSUM: begin
				req_csum = b;
				req_pos = REQ_END;
			end
			REQ_END: begin
				// anything but the end delimiter is ignored here
				if (b == end_delim) begin
					req_pos = REQ_IDLE;
					s = req_sum + b;
					s = -s;
					if (s != req_csum) begin
						push_beat(EV_REQ_CSUM, 8'h00, 1'b1);
					end else begin
						rsp[0] = start_delim;
						rsp[1] = level_type_code;
						rsp[2] = RESP_LEN_BYTE;
						rsp[3] = 8'h00;
						rsp[4] = level[15:8];
						rsp[5] = level[7:0];
						rsp[6] = end_delim;
						s = 8'h00;
						for (int i = 0; i < 7; i++)
							s += rsp[i];
						rsp[3] = -s;
						for (int i = 0; i < 7; i++)
							push_beat(EV_RESPONSE, rsp[i], i == 6);
					end
				end
			end
			default: req_pos = REQ_IDLE;
		endcase
	endfunction

	function void note_input(in_item_t it);
		if (it.command)
			parse_req(it.rx_byte);
		else
			parse_meas(it.rx_byte);
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		if (awaited.size() == 0) begin
			$display("%0t: unexpected result beat, expected none actual event %0d byte %02h",
				$time, got.event_res, got.tx_byte);
			errors++;
			return;
		end
		want = awaited.pop_front();
		compare_field("event_res", want.event_res, got.event_res);
		compare_field("tx_byte", want.tx_byte, got.tx_byte);
		compare_field("last", want.last, got.last);
		compare_field("level", want.level, got.level);
		compare_field("update_count", want.update_count, got.update_count);
	endfunction
endclass

module level_frame_parser_responder_test;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [7:0]  cfg_data;

	frame_tracker tracker = new;

	logic [7:0]  meas_bytes[$];
	logic [7:0]  req_bytes[$];
	int          sent_count = 0;
	int          burst_left = 0;
	int          cycle_count = 0;
	int          mode_cycles = 0;
	int          hold_left = 0;
	bit          hold_armed = 1'b0;
	bit          hold_done = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;

	level_frame_parser_responder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: check accepted beats, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(out_data);
		mode_cycles++;
		if (mode_cycles % 50 == 0)
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && hold_armed) begin
			// long hold-off so the job queue fills and the input stalls
			hold_done = 1'b1;
			hold_left = 300;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
				default:     out_stall <= (mode_cycles % 4 != 0);
			endcase
		end
	end

	task automatic send_byte(logic cmd, logic [7:0] b);
		in_item_t it;
		it.command = cmd;
		it.rx_byte = b;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_input(it);
		sent_count++;
		burst_left--;
	endtask

	// send queued bytes, mixing the two links, until only keep are left
	task automatic pump(int keep);
		bit pick_req;
		while (meas_bytes.size() + req_bytes.size() > keep) begin
			pick_req = (meas_bytes.size() == 0) ||
				(req_bytes.size() != 0 && $urandom_range(0, 1) == 1);
			if (pick_req)
				send_byte(1'b1, req_bytes.pop_front());
			else
				send_byte(1'b0, meas_bytes.pop_front());
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_regs(logic [7:0] sd, logic [7:0] ed, logic [7:0] lt,
			logic [7:0] rt);
		logic [7:0] idx [4];
		logic [7:0] vals [4];
		idx[0] = REG_START_DELIM;
		idx[1] = REG_END_DELIM;
		idx[2] = REG_LEVEL_TYPE;
		idx[3] = REG_REQ_TYPE;
		vals[0] = sd;
		vals[1] = ed;
		vals[2] = lt;
		vals[3] = rt;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			tracker.set_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_level_frame(int len, logic [15:0] lvl, bit bad_type, bit bad_csum,
			bit bad_end);
		logic [7:0] f[$];
		logic [7:0] sum;
		f.push_back(tracker.start_delim);
		if (bad_type) begin
			meas_bytes.push_back(tracker.start_delim);
			meas_bytes.push_back(tracker.level_type_code ^ 8'($urandom_range(1, 255)));
			return;
		end
		f.push_back(tracker.level_type_code);
		f.push_back(8'(len));
		f.push_back(8'h00);
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				f.push_back(lvl[15:8]);
			else if (i == 1)
				f.push_back(lvl[7:0]);
			else
				f.push_back(8'($urandom_range(0, 255)));
		end
		f.push_back(bad_end ? tracker.end_delim ^ 8'($urandom_range(1, 255)) :
			tracker.end_delim);
		sum = 8'h00;
		foreach (f[k])
			sum += f[k];
		f[3] = -sum;
		if (bad_csum)
			f[3] = f[3] ^ 8'($urandom_range(1, 255));
		foreach (f[k])
			meas_bytes.push_back(f[k]);
	endtask

	task automatic queue_request(bit bad_len, bit bad_csum, int waits);
		logic [7:0] csum;
		req_bytes.push_back(tracker.start_delim);
		req_bytes.push_back(tracker.req_type_code);
		if (bad_len) begin
			req_bytes.push_back(8'($urandom_range(1, 255)));
			return;
		end
		req_bytes.push_back(8'h00);
		// the length byte is not part of the request sum
		csum = tracker.start_delim + tracker.req_type_code + tracker.end_delim;
		csum = -csum;
		if (bad_csum)
			csum = csum ^ 8'($urandom_range(1, 255));
		req_bytes.push_back(csum);
		repeat (waits)
			req_bytes.push_back(tracker.end_delim ^ 8'($urandom_range(1, 255)));
		req_bytes.push_back(tracker.end_delim);
	endtask

	task automatic queue_random_frame();
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(0, 1);
				1: len = $urandom_range(7, 24);
				default: len = $urandom_range(2, 6);
			endcase
			queue_level_frame(len, 16'($urandom), $urandom_range(0, 19) == 0,
				$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
		end else if (r < 85) begin
			queue_request($urandom_range(0, 11) == 0, $urandom_range(0, 6) == 0,
				($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
		end else begin
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 1) == 1)
					req_bytes.push_back(8'($urandom_range(0, 255)));
				else
					meas_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		int target_bytes;
		int target_beats;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under the reset settings
		queue_level_frame(2, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		queue_request(1'b0, 1'b0, 0);
		queue_request(1'b0, 1'b1, 0);
		queue_level_frame(0, 16'h0000, 1'b0, 1'b0, 1'b1);
		pump(0);
		settle();

		for (int p = 1; p <= 4; p++) begin
			// leave a level frame half parsed across the register change
			queue_level_frame($urandom_range(2, 4), 16'($urandom), 1'b0, 1'b0, 1'b0);
			repeat (3) send_byte(1'b0, meas_bytes.pop_front());
			settle();
			case (p)
				1: write_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				2: write_regs(8'h00, 8'hFF, 8'hFF, 8'h00);
				3: write_regs(8'hFF, 8'h00, 8'h00, 8'hFF);
				default: write_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			if (p == 1) begin
				// a run of requests while the result side holds off
				hold_armed = 1'b1;
				repeat (6) queue_request(1'b0, 1'b0, 0);
				pump(0);
			end
			if (p == 2) begin
				queue_level_frame(40, 16'($urandom), 1'b0, 1'b0, 1'b0);
				pump(0);
			end
			target_bytes = sent_count + 18;
			target_beats = tracker.predicted + 10;
			while (sent_count < target_bytes || tracker.predicted < target_beats) begin
				queue_random_frame();
				pump(10);
			end
			pump(0);
			settle();
		end

		if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lfpr_pkg.sv
rtl/lfpr_front.sv
rtl/lfpr_queue.sv
rtl/lfpr_back.sv
rtl/level_frame_parser_responder.sv
rtl/lfpr_checker.sv
tb/sv/level_frame_parser_responder_test.sv
